FILE: sv/ipct_pkg.sv
// Shared types, constants and a helper function of the packet counter table.
package ipct_pkg;

    localparam int MAX_PREFIX_BITS = 16;
    localparam int ENTRIES = 16;
    localparam int HEAD_DEPTH = 1 << MAX_PREFIX_BITS;
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam int PFX_W = 5;
    localparam int OCTETS = MAX_PREFIX_BITS / 8 + 1;
    localparam logic [PTR_W-1:0] NO_SLOT = PTR_W'(ENTRIES);

    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_AGE = 2'd1;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_LOST = 3'd2;
    localparam logic [2:0] ST_AGED = 3'd3;
    localparam logic [2:0] ST_READ = 3'd4;

    localparam logic REG_PREFIX_LEN = 1'b0;
    localparam logic REG_AGE_LIMIT = 1'b1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [MAX_PREFIX_BITS-1:0] bucket;
        logic [31:0] ip_address;
        logic [31:0] host_mask;
        logic [3:0] slot_index;
        logic [31:0] now;
    } item_t;

    function automatic logic [MAX_PREFIX_BITS-1:0] bucket_of(logic [31:0] ip,
                                                              logic [PFX_W-1:0] p);
        logic [8*OCTETS-1:0] v;
        logic [PFX_W-1:0] whole;
        logic [2:0] part;
        logic [7:0] oct;
        v = '0;
        whole = p >> 3;
        part = p[2:0];
        for (int i = 0; i < OCTETS; i++) begin
            oct = (i < 4) ? ip[31-8*(i%4) -: 8] : 8'd0;
            if (PFX_W'(i) < whole) begin
                v[8*i +: 8] = oct;
            end else if (PFX_W'(i) == whole && part != 3'd0) begin
                v[8*i +: 8] = oct >> (4'd8 - {1'b0, part});
            end
        end
        return v[MAX_PREFIX_BITS-1:0];
    endfunction

endpackage

FILE: sv/ip_packet_counter_table_with_aging_unit.sv
// Top level of the per-address packet counter table with aging.
//
// A request is taken at a rising edge where start is high and busy is low.
// cmd selects a packet count (0), aging of one bucket (1) or a slot read (2, 3).
// Each request gives exactly one result, shown for one cycle with done high.
// A front end classifies the request and places it in a two-entry queue,
// so busy rises only when that queue is full or the head store is clearing.
// A read is answered from the queue head without a chain walk. A packet or
// an age request first reads the bucket head, then walks the chain, one
// entry per cycle, for at most 16 entries; a packet stops at the first match,
// else it inserts or is lost at the chain end. A request waiting in the
// queue also waits for the requests ahead of it.
// After reset the engine clears all 65536 entries of the bucket head memory,
// one entry a cycle; busy stays high meanwhile. Configuration writes over the
// APB port are taken at any time and should be made while no request is open.
// The receiver cannot hold results off.
module ip_packet_counter_table_with_aging_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [31:0] ip_address,
    input  logic [15:0] bucket_index,
    input  logic [3:0]  slot_index,
    input  logic [31:0] now,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  slot,
    output logic [31:0] count,
    output logic [31:0] entry_ip,
    output logic [31:0] last_seen,
    output logic        entry_valid,
    output logic [4:0]  removed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ipct_pkg::*;

    logic [PFX_W-1:0] prefix_len_reg;
    logic [15:0]      age_limit_reg;
    item_t            f_item, q_item;
    logic             q_empty, q_full, q_pop, clearing, push;
    logic             reg_sel;

    assign pready = 1'b1;
    assign reg_sel = paddr[2];
    assign prdata = (reg_sel == REG_AGE_LIMIT) ? {16'd0, age_limit_reg}
                                               : {27'd0, prefix_len_reg};
    assign busy = q_full || clearing;
    assign push = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_len_reg <= PFX_W'(16);
            age_limit_reg <= 16'd2;
        end
        else if (psel && penable && pwrite)
        begin
            if (reg_sel == REG_PREFIX_LEN)
            begin
                prefix_len_reg <= pwdata[PFX_W-1:0];
            end
            else
            begin
                age_limit_reg <= pwdata[15:0];
            end
        end
    end

    ipct_front u_front (
        .cmd          (cmd),
        .ip_address   (ip_address),
        .bucket_index (bucket_index),
        .slot_index   (slot_index),
        .now          (now),
        .prefix_len   (prefix_len_reg),
        .item         (f_item)
    );

    ipct_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (f_item),
        .pop       (q_pop),
        .head_item (q_item),
        .empty     (q_empty),
        .full      (q_full)
    );

    ipct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (q_item),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .age_limit   (age_limit_reg),
        .clearing    (clearing),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .count       (count),
        .entry_ip    (entry_ip),
        .last_seen   (last_seen),
        .entry_valid (entry_valid),
        .removed     (removed)
    );

endmodule

FILE: sv/ipct_front.sv
// Front end: classifies an incoming request into a queue item.
module ipct_front (
    input  logic [1:0]                        cmd,
    input  logic [31:0]                       ip_address,
    input  logic [15:0]                       bucket_index,
    input  logic [3:0]                        slot_index,
    input  logic [31:0]                       now,
    input  logic [ipct_pkg::PFX_W-1:0]        prefix_len,
    output ipct_pkg::item_t                   item
);
    import ipct_pkg::*;

    logic [PFX_W-1:0] eff_p;

    always_comb
    begin
        eff_p = (prefix_len > PFX_W'(MAX_PREFIX_BITS)) ? PFX_W'(MAX_PREFIX_BITS) : prefix_len;
        item.cmd = cmd;
        item.ip_address = ip_address;
        item.slot_index = slot_index;
        item.now = now;
        item.host_mask = (eff_p == '0) ? 32'hFFFF_FFFF : (32'hFFFF_FFFF >> eff_p);
        if (cmd == CMD_AGE) begin
            item.bucket = MAX_PREFIX_BITS'(bucket_index);
        end else begin
            item.bucket = bucket_of(ip_address, eff_p);
        end
    end

endmodule

FILE: sv/ipct_queue.sv
// Two-entry queue that decouples the front end from the table engine.
module ipct_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipct_pkg::item_t   push_item,
    input  logic              pop,
    output ipct_pkg::item_t   head_item,
    output logic              empty,
    output logic              full
);
    import ipct_pkg::*;

    item_t      store_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full = (cnt_reg == 2'd2);
    assign head_item = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: sv/ipct_back.sv
// Table engine: head memory, entry slots, chain walks and result register.
module ipct_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ipct_pkg::item_t   q_item,
    input  logic              q_empty,
    output logic              q_pop,
    input  logic [15:0]       age_limit,
    output logic              clearing,
    output logic              done,
    output logic [2:0]        status,
    output logic [3:0]        slot,
    output logic [31:0]       count,
    output logic [31:0]       entry_ip,
    output logic [31:0]       last_seen,
    output logic              entry_valid,
    output logic [4:0]        removed
);
    import ipct_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HEAD  = 5'b00100,
        S_PWALK = 5'b01000,
        S_AWALK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [PTR_W-1:0] head_mem [HEAD_DEPTH];
    logic [PTR_W-1:0] head_rdata_reg;
    logic             hw_en;
    logic [MAX_PREFIX_BITS-1:0] hw_addr;
    logic [PTR_W-1:0] hw_data;
    logic [MAX_PREFIX_BITS-1:0] clr_cnt_reg;

    logic [31:0]      e_addr_reg [ENTRIES];
    logic [31:0]      e_count_reg [ENTRIES];
    logic [31:0]      e_time_reg [ENTRIES];
    logic [PTR_W-1:0] e_next_reg [ENTRIES];
    logic [ENTRIES-1:0] e_live_reg;
    logic [SLOT_W-1:0] stack_reg [ENTRIES];
    logic [PTR_W-1:0] fresh_reg;
    logic [PTR_W-1:0] depth_reg;

    item_t            item_reg;
    logic [PTR_W-1:0] cur_reg, prev_reg, tail_reg;
    logic [PTR_W-1:0] steps_reg;
    logic [4:0]       removed_reg;

    logic [SLOT_W-1:0] cur_idx;
    logic [SLOT_W-1:0] q_slot;
    logic             cur_ok, hit, expired, have_fresh, have_free, can_alloc;
    logic [SLOT_W-1:0] alloc_slot;
    logic [PTR_W-1:0] nxt;
    logic [PTR_W-1:0] depth_dec;
    logic [31:0]      age;
    logic             read_now;
    logic             done_next;

    always_comb
    begin
        cur_idx = cur_reg[SLOT_W-1:0];
        q_slot = SLOT_W'(q_item.slot_index);
        cur_ok = (cur_reg < PTR_W'(ENTRIES)) && (steps_reg < PTR_W'(ENTRIES));
        hit = ((e_addr_reg[cur_idx] ^ item_reg.ip_address) & item_reg.host_mask) == 32'd0;
        age = item_reg.now - e_time_reg[cur_idx];
        expired = age >= {16'd0, age_limit};
        nxt = e_next_reg[cur_idx];
        have_fresh = fresh_reg < PTR_W'(ENTRIES);
        have_free = depth_reg != '0;
        can_alloc = have_fresh || have_free;
        depth_dec = depth_reg - PTR_W'(1);
        alloc_slot = have_fresh ? fresh_reg[SLOT_W-1:0] : stack_reg[depth_dec[SLOT_W-1:0]];
        q_pop = (state_reg == S_IDLE) && !q_empty;
        read_now = q_pop && q_item.cmd[1];
        clearing = (state_reg == S_CLEAR);
        done_next = read_now
                    || ((state_reg == S_PWALK) && !(cur_ok && !hit))
                    || ((state_reg == S_AWALK) && !cur_ok);
    end

    always_comb
    begin
        hw_en = 1'b0;
        hw_addr = item_reg.bucket;
        hw_data = NO_SLOT;
        unique case (state_reg)
            S_CLEAR:
            begin
                hw_en = 1'b1;
                hw_addr = clr_cnt_reg;
            end
            S_PWALK:
            begin
                if (!cur_ok && can_alloc && tail_reg >= PTR_W'(ENTRIES))
                begin
                    hw_en = 1'b1;
                    hw_data = {1'b0, alloc_slot};
                end
            end
            S_AWALK:
            begin
                if (cur_ok && expired && prev_reg >= PTR_W'(ENTRIES))
                begin
                    hw_en = 1'b1;
                    hw_data = nxt;
                end
            end
            default:
            begin
                hw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            head_mem[hw_addr] <= hw_data;
        end
        head_rdata_reg <= head_mem[q_item.bucket];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == MAX_PREFIX_BITS'(HEAD_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_pop && !q_item.cmd[1])
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = (item_reg.cmd == CMD_AGE) ? S_AWALK : S_PWALK;
            end
            S_PWALK:
            begin
                if (!cur_ok || hit)
                begin
                    state_next = S_IDLE;
                end
            end
            S_AWALK:
            begin
                if (!cur_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Entry payload and result fields carry no reset.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_item;
        end
        if (read_now)
        begin
            status <= ST_READ;
            slot <= q_item.slot_index;
            removed <= 5'd0;
            entry_valid <= e_live_reg[q_slot];
            count <= e_live_reg[q_slot] ? e_count_reg[q_slot] : 32'd0;
            entry_ip <= e_live_reg[q_slot] ? e_addr_reg[q_slot] : 32'd0;
            last_seen <= e_live_reg[q_slot] ? e_time_reg[q_slot] : 32'd0;
        end
        if (state_reg == S_HEAD)
        begin
            cur_reg <= head_rdata_reg;
            prev_reg <= NO_SLOT;
            tail_reg <= NO_SLOT;
            steps_reg <= '0;
            removed_reg <= 5'd0;
        end
        if (state_reg == S_PWALK)
        begin
            entry_ip <= 32'd0;
            last_seen <= 32'd0;
            entry_valid <= 1'b0;
            removed <= 5'd0;
            if (cur_ok && hit)
            begin
                if (e_count_reg[cur_idx] != 32'hFFFF_FFFF)
                begin
                    e_count_reg[cur_idx] <= e_count_reg[cur_idx] + 32'd1;
                    count <= e_count_reg[cur_idx] + 32'd1;
                end
                else
                begin
                    count <= e_count_reg[cur_idx];
                end
                e_time_reg[cur_idx] <= item_reg.now;
                status <= ST_UPDATED;
                slot <= cur_idx;
            end
            else if (cur_ok)
            begin
                tail_reg <= cur_reg;
                cur_reg <= nxt;
                steps_reg <= steps_reg + PTR_W'(1);
            end
            else if (can_alloc)
            begin
                e_addr_reg[alloc_slot] <= item_reg.ip_address;
                e_count_reg[alloc_slot] <= 32'd1;
                e_time_reg[alloc_slot] <= item_reg.now;
                e_next_reg[alloc_slot] <= NO_SLOT;
                if (tail_reg < PTR_W'(ENTRIES))
                begin
                    e_next_reg[tail_reg[SLOT_W-1:0]] <= {1'b0, alloc_slot};
                end
                status <= ST_INSERTED;
                slot <= alloc_slot;
                count <= 32'd1;
            end
            else
            begin
                status <= ST_LOST;
                slot <= '0;
                count <= 32'd0;
            end
        end
        if (state_reg == S_AWALK)
        begin
            if (cur_ok)
            begin
                steps_reg <= steps_reg + PTR_W'(1);
                cur_reg <= nxt;
                if (expired)
                begin
                    if (prev_reg < PTR_W'(ENTRIES))
                    begin
                        e_next_reg[prev_reg[SLOT_W-1:0]] <= nxt;
                    end
                    e_next_reg[cur_idx] <= NO_SLOT;
                    if (depth_reg < PTR_W'(ENTRIES))
                    begin
                        stack_reg[depth_reg[SLOT_W-1:0]] <= cur_idx;
                    end
                    removed_reg <= removed_reg + 5'd1;
                end
                else
                begin
                    prev_reg <= cur_reg;
                end
            end
            else
            begin
                status <= ST_AGED;
                slot <= '0;
                count <= 32'd0;
                entry_ip <= 32'd0;
                last_seen <= 32'd0;
                entry_valid <= 1'b0;
                removed <= removed_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
            e_live_reg <= '0;
            fresh_reg <= '0;
            depth_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= done_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MAX_PREFIX_BITS'(1);
            end
            if (state_reg == S_PWALK && !(cur_ok && !hit))
            begin
                if (!cur_ok && can_alloc)
                begin
                    e_live_reg[alloc_slot] <= 1'b1;
                    if (have_fresh)
                    begin
                        fresh_reg <= fresh_reg + PTR_W'(1);
                    end
                    else
                    begin
                        depth_reg <= depth_dec;
                    end
                end
            end
            if (state_reg == S_AWALK)
            begin
                if (cur_ok && expired)
                begin
                    e_live_reg[cur_idx] <= 1'b0;
                    if (depth_reg < PTR_W'(ENTRIES))
                    begin
                        depth_reg <= depth_reg + PTR_W'(1);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_ip_packet_counter_table_with_aging_unit.sv
// Testbench for the packet counter table: directed and random requests checked against a local model.
module tb_ip_packet_counter_table_with_aging_unit;
    import ipct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_READ_ALT = 2'd3;
    localparam int END_WAIT = 40;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot;
        logic [31:0] count;
        logic [31:0] entry_ip;
        logic [31:0] last_seen;
        logic entry_valid;
        logic [4:0] removed;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] cmd = '0;
    logic [31:0] ip_address = '0;
    logic [15:0] bucket_index = '0;
    logic [3:0] slot_index = '0;
    logic [31:0] now = '0;
    logic done;
    logic [2:0] status;
    logic [3:0] slot;
    logic [31:0] count;
    logic [31:0] entry_ip;
    logic [31:0] last_seen;
    logic entry_valid;
    logic [4:0] removed;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ip_packet_counter_table_with_aging_unit uut (.*);

    always #5 clk = ~clk;

    // Local copy of the table state and registers.
    int head_of [HEAD_DEPTH];
    logic [31:0] addr_of [ENTRIES];
    logic [31:0] hits_of [ENTRIES];
    logic [31:0] stamp_of [ENTRIES];
    int next_of [ENTRIES];
    bit live_of [ENTRIES];
    int fresh_slot;
    int free_slots [ENTRIES];
    int free_top;
    logic [4:0] prefix_reg;
    logic [15:0] expiry_reg;

    outcome_t pending_outcomes[$];
    int mismatches = 0;
    int burst_left = 0;
    logic [31:0] clock_now = 32'd100;
    logic [31:0] ip_pool[$];

    function automatic int eff_prefix();
        return (prefix_reg > MAX_PREFIX_BITS) ? MAX_PREFIX_BITS : int'(prefix_reg);
    endfunction

    function automatic logic [15:0] bucket_for(logic [31:0] ip, int p);
        logic [31:0] v;
        int whole;
        int part;
        v = '0;
        whole = p / 8;
        part = p % 8;
        for (int i = 0; i < whole; i++) begin
            v |= ((ip >> (24 - 8 * i)) & 32'hFF) << (8 * i);
        end
        if (part != 0) begin
            v |= (((ip >> (24 - 8 * whole)) & 32'hFF) >> (8 - part)) << (8 * whole);
        end
        return v[15:0];
    endfunction

    function automatic logic [31:0] host_for(logic [31:0] ip, int p);
        return (p == 0) ? ip : (ip & (32'hFFFF_FFFF >> p));
    endfunction

    function automatic void model_reset();
        foreach (head_of[i]) head_of[i] = ENTRIES;
        foreach (next_of[i]) next_of[i] = ENTRIES;
        foreach (live_of[i]) live_of[i] = 1'b0;
        fresh_slot = 0;
        free_top = 0;
        prefix_reg = 5'd16;
        expiry_reg = 16'd2;
    endfunction

    function automatic outcome_t count_packet(logic [31:0] ip, logic [31:0] t);
        outcome_t r;
        int p;
        int b;
        int cur;
        int tail;
        int steps;
        int s;
        r = '0;
        p = eff_prefix();
        b = int'(bucket_for(ip, p));
        cur = head_of[b];
        tail = ENTRIES;
        steps = 0;
        while (cur < ENTRIES && steps < ENTRIES) begin
            steps++;
            if (host_for(addr_of[cur], p) == host_for(ip, p)) begin
                if (hits_of[cur] != 32'hFFFF_FFFF) hits_of[cur]++;
                stamp_of[cur] = t;
                r.status = ST_UPDATED;
                r.slot = cur[3:0];
                r.count = hits_of[cur];
                return r;
            end
            tail = cur;
            cur = next_of[cur];
        end
        if (fresh_slot < ENTRIES) begin
            s = fresh_slot++;
        end else if (free_top > 0) begin
            free_top--;
            s = free_slots[free_top];
        end else begin
            r.status = ST_LOST;
            return r;
        end
        addr_of[s] = ip;
        hits_of[s] = 32'd1;
        stamp_of[s] = t;
        next_of[s] = ENTRIES;
        live_of[s] = 1'b1;
        if (tail < ENTRIES) next_of[tail] = s;
        else head_of[b] = s;
        r.status = ST_INSERTED;
        r.slot = s[3:0];
        r.count = 32'd1;
        return r;
    endfunction

    function automatic outcome_t age_bucket(logic [15:0] b, logic [31:0] t);
        outcome_t r;
        int prev;
        int cur;
        int nxt;
        int steps;
        int freed;
        r = '0;
        prev = ENTRIES;
        cur = head_of[b];
        steps = 0;
        freed = 0;
        while (cur < ENTRIES && steps < ENTRIES) begin
            steps++;
            nxt = next_of[cur];
            if (32'(t - stamp_of[cur]) >= {16'd0, expiry_reg}) begin
                if (prev < ENTRIES) next_of[prev] = nxt;
                else head_of[b] = nxt;
                next_of[cur] = ENTRIES;
                live_of[cur] = 1'b0;
                if (free_top < ENTRIES) free_slots[free_top++] = cur;
                freed++;
            end else begin
                prev = cur;
            end
            cur = nxt;
        end
        r.status = ST_AGED;
        r.removed = freed[4:0];
        return r;
    endfunction

    function automatic outcome_t read_slot(logic [3:0] s);
        outcome_t r;
        r = '0;
        r.status = ST_READ;
        r.slot = s;
        if (live_of[s]) begin
            r.count = hits_of[s];
            r.entry_ip = addr_of[s];
            r.last_seen = stamp_of[s];
            r.entry_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic send_request(logic [1:0] c, logic [31:0] ip, logic [15:0] b,
                                logic [3:0] s, logic [31:0] t);
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 25)) @(negedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        cmd <= c;
        ip_address <= ip;
        bucket_index <= b;
        slot_index <= s;
        now <= t;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (c == CMD_PACKET) pending_outcomes.push_back(count_packet(ip, t));
        else if (c == CMD_AGE) pending_outcomes.push_back(age_bucket(b, t));
        else pending_outcomes.push_back(read_slot(s));
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        burst_left = 0;
        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (END_WAIT) @(negedge clk);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_PREFIX_LEN) prefix_reg = value[4:0];
        else expiry_reg = value[15:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    always @(posedge clk) begin
        outcome_t got;
        outcome_t want;
        if (rst_n && done) begin
            got = '{status, slot, count, entry_ip, last_seen, entry_valid, removed};
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result: %p", got);
            end else begin
                want = pending_outcomes.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    function automatic logic [31:0] pick_ip();
        logic [31:0] ip;
        if (ip_pool.size() != 0 && $urandom_range(0, 2) != 0) begin
            ip = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
            if ($urandom_range(0, 3) == 0) ip ^= 32'(1) << $urandom_range(0, 31);
        end else begin
            ip = $urandom();
            ip_pool.push_back(ip);
            if (ip_pool.size() > 24) void'(ip_pool.pop_front());
        end
        return ip;
    endfunction

    task automatic test_directed();
        send_request(CMD_PACKET, 32'h0000_0000, '0, '0, clock_now);
        send_request(CMD_PACKET, 32'hFFFF_FFFF, '0, '0, clock_now + 1);
        send_request(CMD_PACKET, 32'hFFFF_FFFF, '0, '0, clock_now + 2);
        send_request(CMD_PACKET, 32'hFFFF_0001, '0, '0, clock_now + 3);
        send_request(CMD_READ, '0, '0, 4'd1, '0);
        send_request(CMD_READ_ALT, '0, '0, 4'd15, '0);
        send_request(CMD_AGE, '0, 16'hFFFF, '0, clock_now + 3);
        send_request(CMD_AGE, '0, 16'hFFFF, '0, 32'hFFFF_FFFF);
        send_request(CMD_READ, '0, '0, 4'd1, '0);
        write_register(REG_PREFIX_LEN, 32'd0);
        for (int i = 0; i < 17; i++) begin
            send_request(CMD_PACKET, 32'hA000_0000 + i, '0, '0, clock_now + i);
        end
        write_register(REG_AGE_LIMIT, 32'd0);
        send_request(CMD_AGE, '0, 16'h0000, '0, '0);
        write_register(REG_PREFIX_LEN, 32'd31);
        write_register(REG_AGE_LIMIT, 32'd65535);
    endtask

    task automatic test_random(int n);
        logic [31:0] ip;
        int sel;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) clock_now = $urandom();
            else clock_now += $urandom_range(0, 3);
            sel = $urandom_range(0, 9);
            ip = pick_ip();
            if (sel < 6) begin
                send_request(CMD_PACKET, ip, 16'($urandom()), 4'($urandom()), clock_now);
            end else if (sel < 8) begin
                send_request(CMD_AGE, ip, ($urandom_range(0, 4) == 0) ? 16'($urandom())
                             : bucket_for(ip, eff_prefix()), 4'($urandom()), clock_now);
            end else begin
                send_request(2'($urandom_range(CMD_READ, CMD_READ_ALT)), ip, 16'($urandom()),
                             4'($urandom()), clock_now);
            end
        end
    endtask

    task automatic test_settings();
        int prefixes [5] = '{1, 8, 12, 16, 20};
        int expiries [4] = '{0, 1, 5, 65535};
        for (int k = 0; k < 5; k++) begin
            write_register(REG_PREFIX_LEN, prefixes[k]);
            write_register(REG_AGE_LIMIT, expiries[k % 4]);
            test_random(105);
        end
    endtask

    initial begin
        model_reset();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_settings();
        drain();
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
sv/ipct_pkg.sv
sv/ipct_front.sv
sv/ipct_queue.sv
sv/ipct_back.sv
sv/ip_packet_counter_table_with_aging_unit.sv
dv/tb_ip_packet_counter_table_with_aging_unit.sv
